>>> src/uqcf_pkg.sv
// ----------------------------------------------------------------------------
// UDP query challenge filter package
// Shared item types, action and verdict codes, and query patterns.
// ----------------------------------------------------------------------------
package uqcf_pkg;

    typedef enum logic [1:0] {
        ACT_OTHER  = 2'd0,
        ACT_UDP    = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        VERDICT_FORWARD   = 3'd0,
        VERDICT_DROP      = 3'd1,
        VERDICT_CHALLENGE = 3'd2,
        VERDICT_INFO      = 3'd3,
        VERDICT_PLAYER    = 3'd4,
        VERDICT_RULES     = 3'd5,
        VERDICT_WRITTEN   = 3'd6,
        VERDICT_RESERVED  = 3'd7
    } t_verdict;

    localparam logic [7:0] CFG_EXPIRY = 8'd0;
    localparam logic [7:0] CFG_WINDOW = 8'd1;

    localparam logic [63:0] INFO_LO     = 64'h756F5354FFFFFFFF;
    localparam logic [63:0] INFO_HI     = 64'h69676E4520656372;
    localparam logic [39:0] PLAYER_HEAD = 40'h55FFFFFFFF;
    localparam logic [39:0] RULES_HEAD  = 40'h56FFFFFFFF;
    localparam logic [15:0] SHORT_LEN   = 16'd9;
    localparam logic [15:0] INFO_LEN    = 16'd25;
    localparam logic [15:0] INFO_CK_LEN = 16'd29;
    localparam logic [15:0] CHAL_LEN    = 16'd9;

    typedef struct packed {
        t_action     action;
        logic [31:0] dst_ip;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [15:0] payload_length;
        logic [63:0] payload_low_bytes;
        logic [63:0] payload_mid_bytes;
        logic [31:0] payload_tail_bytes;
        logic [31:0] now_seconds;
        logic [5:0]  slot_index;
        logic [1:0]  entry_flags;
        logic [47:0] response_lengths;
    } t_item;

    typedef struct packed {
        logic        found;
        logic [31:0] last_seen;
        logic        strict;
        logic [47:0] lengths;
    } t_hit;

endpackage

>>> src/uqcf_cell.sv
// ----------------------------------------------------------------------------
// UDP query challenge filter table cell
// Holds one table slot, applies writes aimed at it and records the first hit
// of each lookup as the transaction passes to the next cell.
// ----------------------------------------------------------------------------
module uqcf_cell #(
    parameter int SLOT_W = 6,
    parameter int INDEX  = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  uqcf_pkg::t_item    i_item,
    input  uqcf_pkg::t_hit     i_hit,
    input  logic [SLOT_W-1:0]  i_slot,
    output logic               o_vld,
    output uqcf_pkg::t_item    o_item,
    output uqcf_pkg::t_hit     o_hit,
    output logic [SLOT_W-1:0]  o_slot
);

    logic              r_valid;
    logic [31:0]       r_addr;
    logic [15:0]       r_port;
    logic [31:0]       r_seen;
    logic              r_strict;
    logic [47:0]       r_lens;

    logic              r_vld;
    uqcf_pkg::t_item   r_item;
    uqcf_pkg::t_hit    r_hit;
    logic [SLOT_W-1:0] r_slot;

    logic              w_match;
    logic              w_write;

    assign w_match = i_vld && (i_item.action == uqcf_pkg::ACT_UDP) && !i_hit.found
                     && r_valid && (r_addr == i_item.dst_ip) && (r_port == i_item.dest_port);
    assign w_write = i_vld && (i_item.action == uqcf_pkg::ACT_WRITE)
                     && (11'(i_item.slot_index) == 11'(INDEX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_vld   <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
            if (w_write) begin
                r_valid <= i_item.entry_flags[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= i_item;
            if (w_match) begin
                r_hit.found     <= 1'b1;
                r_hit.last_seen <= r_seen;
                r_hit.strict    <= r_strict;
                r_hit.lengths   <= r_lens;
                r_slot          <= SLOT_W'(INDEX);
            end else begin
                r_hit  <= i_hit;
                r_slot <= i_slot;
            end
            if (w_write) begin
                r_addr   <= i_item.dst_ip;
                r_port   <= i_item.dest_port;
                r_seen   <= i_item.now_seconds;
                r_strict <= i_item.entry_flags[1];
                r_lens   <= i_item.response_lengths;
            end
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
    assign o_hit  = r_hit;
    assign o_slot = r_slot;

endmodule

>>> src/uqcf_classify.sv
// ----------------------------------------------------------------------------
// UDP query challenge filter classifier
// Turns a finished lookup into a verdict, cookie and reply length, and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module uqcf_classify #(
    parameter int SLOT_W = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  uqcf_pkg::t_item    i_item,
    input  uqcf_pkg::t_hit     i_hit,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [7:0]         i_expiry_limit,
    input  logic [7:0]         i_cookie_window,
    output logic               o_vld,
    output logic [2:0]         o_verdict,
    output logic [31:0]        o_cookie,
    output logic [15:0]        o_len,
    output logic [5:0]         o_slot
);

    logic               r_vld;
    uqcf_pkg::t_verdict r_verdict;
    logic [31:0]        r_cookie;
    logic [15:0]        r_len;
    logic [5:0]         r_slot;

    uqcf_pkg::t_verdict n_verdict;
    logic [31:0]        n_cookie;
    logic [15:0]        n_len;
    logic [5:0]         n_slot;

    logic [31:0] w_ports;
    logic [39:0] w_head;
    logic [31:0] w_short_ck;
    logic        w_no_body;
    logic        w_info;
    logic        w_short_q;
    logic        w_stale;
    logic [31:0] w_stamp;
    logic [31:0] w_diff;
    logic        w_ck_ok;

    assign w_ports    = {i_item.source_port, i_item.dest_port};
    assign w_head     = i_item.payload_low_bytes[39:0];
    assign w_short_ck = {i_item.payload_mid_bytes[7:0], i_item.payload_low_bytes[63:40]};
    assign w_no_body  = (w_short_ck == 32'd0);
    assign w_info     = (i_item.payload_low_bytes == uqcf_pkg::INFO_LO)
                        && (i_item.payload_mid_bytes == uqcf_pkg::INFO_HI);
    assign w_short_q  = (i_item.payload_length == uqcf_pkg::SHORT_LEN)
                        && ((w_head == uqcf_pkg::PLAYER_HEAD)
                            || (w_head == uqcf_pkg::RULES_HEAD));
    assign w_stale    = (i_item.now_seconds - i_hit.last_seen) > 32'(i_expiry_limit);

    // The info query carries its cookie in the tail bytes, the short queries
    // right after the header byte.
    assign w_stamp = (w_short_q ? w_short_ck : i_item.payload_tail_bytes) - w_ports;
    assign w_diff  = {24'd0, i_item.now_seconds[7:0]} - w_stamp;
    assign w_ck_ok = w_diff <= 32'(i_cookie_window);

    always_comb begin
        n_verdict = uqcf_pkg::VERDICT_FORWARD;
        n_cookie  = 32'd0;
        n_len     = 16'd0;
        n_slot    = 6'd0;
        if (i_item.action == uqcf_pkg::ACT_WRITE) begin
            n_verdict = uqcf_pkg::VERDICT_WRITTEN;
        end else if (i_item.action == uqcf_pkg::ACT_UDP && i_hit.found) begin
            n_slot = 6'(i_slot);
            if (w_stale) begin
                n_verdict = uqcf_pkg::VERDICT_DROP;
            end else if (w_short_q && w_no_body) begin
                n_verdict = uqcf_pkg::VERDICT_CHALLENGE;
            end else if (w_short_q) begin
                if (!w_ck_ok) begin
                    n_verdict = uqcf_pkg::VERDICT_DROP;
                end else if (w_head == uqcf_pkg::PLAYER_HEAD) begin
                    n_verdict = uqcf_pkg::VERDICT_PLAYER;
                    n_len     = i_hit.lengths[31:16];
                end else begin
                    n_verdict = uqcf_pkg::VERDICT_RULES;
                    n_len     = i_hit.lengths[47:32];
                end
            end else if (i_item.payload_length == uqcf_pkg::INFO_LEN && w_info) begin
                n_verdict = uqcf_pkg::VERDICT_CHALLENGE;
            end else if (i_item.payload_length == uqcf_pkg::INFO_CK_LEN && w_info) begin
                if (!w_ck_ok) begin
                    n_verdict = uqcf_pkg::VERDICT_DROP;
                end else begin
                    n_verdict = uqcf_pkg::VERDICT_INFO;
                    n_len     = i_hit.lengths[15:0];
                end
            end else if (i_hit.strict) begin
                n_verdict = uqcf_pkg::VERDICT_DROP;
            end
            if (n_verdict == uqcf_pkg::VERDICT_CHALLENGE) begin
                n_cookie = {24'd0, i_item.now_seconds[7:0]} + w_ports;
                n_len    = uqcf_pkg::CHAL_LEN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_verdict <= n_verdict;
            r_cookie  <= n_cookie;
            r_len     <= n_len;
            r_slot    <= n_slot;
        end
    end

    assign o_vld     = r_vld;
    assign o_verdict = r_verdict;
    assign o_cookie  = r_cookie;
    assign o_len     = r_len;
    assign o_slot    = r_slot;

endmodule

>>> src/udp_query_challenge_filter_core.sv
// Pipeline: the input passes through one register per table cell, then the
// classifier's output register.
// Throughput: one transaction per cycle; the whole cell chain advances together
// and halts only while a result waits at a stalled output.
// Reset: synchronous, active low; clears all slot valid bits and loads the
// expiry limit with 10 and the cookie window with 5.
// ----------------------------------------------------------------------------
// UDP query challenge filter core
// Cached-server lookup through a chain of slot cells, followed by query
// classification and challenge-cookie checking.
// ----------------------------------------------------------------------------
module udp_query_challenge_filter_core #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_dst_ip,
    input  logic [15:0] i_dest_port,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_payload_length,
    input  logic [63:0] i_payload_low_bytes,
    input  logic [63:0] i_payload_mid_bytes,
    input  logic [31:0] i_payload_tail_bytes,
    input  logic [31:0] i_now_seconds,
    input  logic [5:0]  i_slot_index,
    input  logic [1:0]  i_entry_flags,
    input  logic [47:0] i_response_lengths,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_verdict,
    output logic [31:0] o_cookie_value,
    output logic [15:0] o_reply_length,
    output logic [5:0]  o_matched_slot,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    logic [7:0] r_expiry_limit;
    logic [7:0] r_cookie_window;
    logic       w_en;

    logic              w_vld  [0:TABLE_SLOTS];
    uqcf_pkg::t_item   w_item [0:TABLE_SLOTS];
    uqcf_pkg::t_hit    w_hit  [0:TABLE_SLOTS];
    logic [SLOT_W-1:0] w_slot [0:TABLE_SLOTS];

    assign w_en        = !(o_valid && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry_limit  <= 8'd10;
            r_cookie_window <= 8'd5;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == uqcf_pkg::CFG_EXPIRY) begin
                r_expiry_limit <= i_cfg_data;
            end else if (i_cfg_index == uqcf_pkg::CFG_WINDOW) begin
                r_cookie_window <= i_cfg_data;
            end
        end
    end

    assign w_vld[0]                       = i_valid;
    assign w_item[0].action               = uqcf_pkg::t_action'(i_action);
    assign w_item[0].dst_ip               = i_dst_ip;
    assign w_item[0].dest_port            = i_dest_port;
    assign w_item[0].source_port          = i_source_port;
    assign w_item[0].payload_length       = i_payload_length;
    assign w_item[0].payload_low_bytes    = i_payload_low_bytes;
    assign w_item[0].payload_mid_bytes    = i_payload_mid_bytes;
    assign w_item[0].payload_tail_bytes   = i_payload_tail_bytes;
    assign w_item[0].now_seconds          = i_now_seconds;
    assign w_item[0].slot_index           = i_slot_index;
    assign w_item[0].entry_flags          = i_entry_flags;
    assign w_item[0].response_lengths     = i_response_lengths;
    assign w_hit[0]                       = '0;
    assign w_slot[0]                      = '0;

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        uqcf_cell #(
            .SLOT_W (SLOT_W),
            .INDEX  (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_item  (w_item[g]),
            .i_hit   (w_hit[g]),
            .i_slot  (w_slot[g]),
            .o_vld   (w_vld[g+1]),
            .o_item  (w_item[g+1]),
            .o_hit   (w_hit[g+1]),
            .o_slot  (w_slot[g+1])
        );
    end

    uqcf_classify #(
        .SLOT_W (SLOT_W)
    ) u_classify (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_vld           (w_vld[TABLE_SLOTS]),
        .i_item          (w_item[TABLE_SLOTS]),
        .i_hit           (w_hit[TABLE_SLOTS]),
        .i_slot          (w_slot[TABLE_SLOTS]),
        .i_expiry_limit  (r_expiry_limit),
        .i_cookie_window (r_cookie_window),
        .o_vld           (o_valid),
        .o_verdict       (o_verdict),
        .o_cookie        (o_cookie_value),
        .o_len           (o_reply_length),
        .o_slot          (o_matched_slot)
    );

`ifndef SYNTHESIS
    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output free");
    a_written_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict == uqcf_pkg::VERDICT_WRITTEN) |->
        (o_cookie_value == 32'd0 && o_matched_slot == 6'd0 && o_reply_length == 16'd0))
        else $error("write result carries lookup data");
    a_challenge_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict == uqcf_pkg::VERDICT_CHALLENGE) |->
        (o_reply_length == uqcf_pkg::CHAL_LEN))
        else $error("challenge with wrong reply length");
    a_no_cookie_else: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict != uqcf_pkg::VERDICT_CHALLENGE) |->
        (o_cookie_value == 32'd0))
        else $error("cookie outside a challenge");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UDP query challenge filter testbench
// Drives directed and random packets and slot writes into the filter core
// with random bursts and output stalls. A scoreboard predicts each verdict
// from its own copy of the slot table and compares every result in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SLOTS = 64;

    typedef enum int {Q_PLAYER, Q_RULES, Q_INFO} t_qkind;
    typedef enum int {CK_NONE, CK_GOOD, CK_BAD} t_cookie_mode;

    typedef struct {
        uqcf_pkg::t_verdict verdict;
        logic [31:0]        cookie;
        logic [15:0]        rlen;
        logic [5:0]         slot;
    } t_verdict_rec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;
    uqcf_pkg::t_item drv_item = '0;

    logic o_stall, o_valid, o_cfg_ready;
    logic [2:0] o_verdict;
    logic [31:0] o_cookie_value;
    logic [15:0] o_reply_length;
    logic [5:0] o_matched_slot;

    // Scoreboard copy of the block's state.
    logic [7:0] expiry_lim = 8'd10;
    logic [7:0] cookie_win = 8'd5;
    logic tbl_valid [SLOTS];
    logic [31:0] tbl_ip [SLOTS];
    logic [15:0] tbl_port [SLOTS];
    logic [31:0] tbl_seen [SLOTS];
    logic tbl_strict [SLOTS];
    logic [47:0] tbl_lens [SLOTS];

    t_verdict_rec verdict_q[$];
    int mismatches = 0;
    int hold_left = 0;
    int burst_left = 0;
    bit no_gaps = 0;
    logic [31:0] cur_now = 32'h0000_1000;
    logic [31:0] pool_ip [6];
    logic [15:0] pool_port [6];

    udp_query_challenge_filter_core #(.TABLE_SLOTS(SLOTS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(drv_item.action), .i_dst_ip(drv_item.dst_ip),
        .i_dest_port(drv_item.dest_port), .i_source_port(drv_item.source_port),
        .i_payload_length(drv_item.payload_length),
        .i_payload_low_bytes(drv_item.payload_low_bytes),
        .i_payload_mid_bytes(drv_item.payload_mid_bytes),
        .i_payload_tail_bytes(drv_item.payload_tail_bytes),
        .i_now_seconds(drv_item.now_seconds), .i_slot_index(drv_item.slot_index),
        .i_entry_flags(drv_item.entry_flags),
        .i_response_lengths(drv_item.response_lengths),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_verdict(o_verdict), .o_cookie_value(o_cookie_value),
        .o_reply_length(o_reply_length), .o_matched_slot(o_matched_slot),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic cookie_valid(logic [31:0] now, logic [31:0] ports,
                                          logic [31:0] ck);
        logic [31:0] diff;
        diff = {24'd0, now[7:0]} - (ck - ports);
        return diff <= {24'd0, cookie_win};
    endfunction

    // Computes the verdict of one transaction and applies slot writes.
    function automatic t_verdict_rec filter_verdict(uqcf_pkg::t_item it);
        t_verdict_rec r;
        logic [31:0] ports, short_ck;
        logic [39:0] head;
        logic is_short, is_info, found;
        int hit;
        r = '{uqcf_pkg::VERDICT_FORWARD, 32'd0, 16'd0, 6'd0};
        found = 0;
        hit = 0;
        if (it.action == uqcf_pkg::ACT_WRITE) begin
            tbl_valid[it.slot_index] = it.entry_flags[0];
            tbl_strict[it.slot_index] = it.entry_flags[1];
            tbl_ip[it.slot_index] = it.dst_ip;
            tbl_port[it.slot_index] = it.dest_port;
            tbl_seen[it.slot_index] = it.now_seconds;
            tbl_lens[it.slot_index] = it.response_lengths;
            r.verdict = uqcf_pkg::VERDICT_WRITTEN;
            return r;
        end
        if (it.action != uqcf_pkg::ACT_UDP) return r;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_ip[i] == it.dst_ip && tbl_port[i] == it.dest_port) begin
                found = 1;
                hit = i;
            end
        end
        if (!found) return r;
        r.slot = hit[5:0];
        ports = {it.source_port, it.dest_port};
        head = it.payload_low_bytes[39:0];
        short_ck = {it.payload_mid_bytes[7:0], it.payload_low_bytes[63:40]};
        is_short = it.payload_length == uqcf_pkg::SHORT_LEN
                   && (head == uqcf_pkg::PLAYER_HEAD || head == uqcf_pkg::RULES_HEAD);
        is_info = it.payload_low_bytes == uqcf_pkg::INFO_LO
                  && it.payload_mid_bytes == uqcf_pkg::INFO_HI;
        if (it.now_seconds - tbl_seen[hit] > {24'd0, expiry_lim}) begin
            r.verdict = uqcf_pkg::VERDICT_DROP;
        end else if (is_short && short_ck == 32'd0) begin
            r.verdict = uqcf_pkg::VERDICT_CHALLENGE;
        end else if (is_short) begin
            if (!cookie_valid(it.now_seconds, ports, short_ck)) begin
                r.verdict = uqcf_pkg::VERDICT_DROP;
            end else if (head == uqcf_pkg::PLAYER_HEAD) begin
                r.verdict = uqcf_pkg::VERDICT_PLAYER;
                r.rlen = tbl_lens[hit][31:16];
            end else begin
                r.verdict = uqcf_pkg::VERDICT_RULES;
                r.rlen = tbl_lens[hit][47:32];
            end
        end else if (it.payload_length == uqcf_pkg::INFO_LEN && is_info) begin
            r.verdict = uqcf_pkg::VERDICT_CHALLENGE;
        end else if (it.payload_length == uqcf_pkg::INFO_CK_LEN && is_info) begin
            if (!cookie_valid(it.now_seconds, ports, it.payload_tail_bytes)) begin
                r.verdict = uqcf_pkg::VERDICT_DROP;
            end else begin
                r.verdict = uqcf_pkg::VERDICT_INFO;
                r.rlen = tbl_lens[hit][15:0];
            end
        end else if (tbl_strict[hit]) begin
            r.verdict = uqcf_pkg::VERDICT_DROP;
        end
        if (r.verdict == uqcf_pkg::VERDICT_CHALLENGE) begin
            r.cookie = {24'd0, it.now_seconds[7:0]} + ports;
            r.rlen = uqcf_pkg::CHAL_LEN;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_verdict_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: verdict %0d", o_verdict);
            end else begin
                want = verdict_q.pop_front();
                if (o_verdict !== want.verdict || o_cookie_value !== want.cookie ||
                    o_reply_length !== want.rlen || o_matched_slot !== want.slot) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected v=%0d ck=%h len=%0d slot=%0d, ",
                                  "got v=%0d ck=%h len=%0d slot=%0d"},
                                 want.verdict, want.cookie, want.rlen, want.slot,
                                 o_verdict, o_cookie_value, o_reply_length, o_matched_slot);
                end
            end
        end
    end

    // Output stall pattern; a pending hold overrides it.
    initial begin
        int mode, left;
        mode = 0;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(5, 60);
                end
                left--;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Called at a rising edge; returns once accepted, after any idle gap.
    task automatic send_item(uqcf_pkg::t_item it);
        int gap;
        drv_item <= it;
        i_valid <= 1'b1;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        verdict_q.push_back(filter_verdict(it));
        if (burst_left > 0) begin
            burst_left--;
        end else if (!no_gaps) begin
            burst_left = $urandom_range(0, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        wait (verdict_q.size() == 0);
        repeat (SLOTS + 10) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [7:0] idx, logic [7:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == uqcf_pkg::CFG_EXPIRY) expiry_lim = val;
        else cookie_win = val;
    endtask

    function automatic uqcf_pkg::t_item random_item();
        uqcf_pkg::t_item it;
        it.action = uqcf_pkg::t_action'($urandom_range(0, 3));
        it.dst_ip = $urandom;
        it.dest_port = 16'($urandom);
        it.source_port = 16'($urandom);
        it.payload_length = 16'($urandom_range(0, 65527));
        it.payload_low_bytes = {$urandom, $urandom};
        it.payload_mid_bytes = {$urandom, $urandom};
        it.payload_tail_bytes = $urandom;
        it.now_seconds = $urandom;
        it.slot_index = 6'($urandom);
        it.entry_flags = 2'($urandom);
        it.response_lengths = 48'({$urandom, $urandom});
        return it;
    endfunction

    function automatic uqcf_pkg::t_item slot_write(int idx, logic [1:0] flags,
                                                   logic [31:0] ip, logic [15:0] port,
                                                   logic [31:0] seen);
        uqcf_pkg::t_item it;
        it = random_item();
        it.action = uqcf_pkg::ACT_WRITE;
        it.slot_index = 6'(idx);
        it.entry_flags = flags;
        it.dst_ip = ip;
        it.dest_port = port;
        it.now_seconds = seen;
        return it;
    endfunction

    function automatic uqcf_pkg::t_item query(t_qkind kind, t_cookie_mode ck,
                                              logic [31:0] ip, logic [15:0] port,
                                              logic [31:0] now, bit bad_len);
        uqcf_pkg::t_item it;
        logic [31:0] ports, c, d;
        it = random_item();
        it.action = uqcf_pkg::ACT_UDP;
        it.dst_ip = ip;
        it.dest_port = port;
        it.now_seconds = now;
        ports = {it.source_port, it.dest_port};
        d = (ck == CK_GOOD) ? $urandom_range(0, cookie_win)
                            : cookie_win + 1 + $urandom_range(0, 1000);
        c = ({24'd0, now[7:0]} - d) + ports;
        if (kind == Q_INFO) begin
            it.payload_low_bytes = uqcf_pkg::INFO_LO;
            it.payload_mid_bytes = uqcf_pkg::INFO_HI;
            it.payload_length = (ck == CK_NONE) ? uqcf_pkg::INFO_LEN : uqcf_pkg::INFO_CK_LEN;
            it.payload_tail_bytes = c;
        end else begin
            it.payload_low_bytes[39:0] = (kind == Q_PLAYER) ? uqcf_pkg::PLAYER_HEAD
                                                            : uqcf_pkg::RULES_HEAD;
            it.payload_low_bytes[63:40] = (ck == CK_NONE) ? 24'd0 : c[23:0];
            it.payload_mid_bytes[7:0] = (ck == CK_NONE) ? 8'd0 : c[31:24];
            it.payload_length = uqcf_pkg::SHORT_LEN;
        end
        if (bad_len) it.payload_length = 16'(it.payload_length + $urandom_range(1, 3));
        return it;
    endfunction

    // One random transaction, mostly well-formed traffic to cached servers.
    task automatic random_traffic();
        uqcf_pkg::t_item it;
        int r, s, k;
        logic [31:0] now;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 5);
        cur_now = cur_now + $urandom_range(0, 3);
        if (r < 12) begin
            s = $urandom_range(0, SLOTS - 1);
            it = slot_write(s, 2'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) * 2 :
                            $urandom_range(0, 1) * 2 + 1), pool_ip[k], pool_port[k], cur_now);
        end else if (r < 80) begin
            s = $urandom_range(0, SLOTS - 1);
            for (int t = 0; t < 20 && !tbl_valid[s]; t++) s = $urandom_range(0, SLOTS - 1);
            if (!tbl_valid[s]) s = 0;
            now = tbl_seen[s] + (($urandom_range(0, 9) == 0) ? $urandom
                                 : $urandom_range(0, expiry_lim + 2));
            it = query(t_qkind'($urandom_range(0, 2)), t_cookie_mode'($urandom_range(0, 2)),
                       tbl_valid[s] ? tbl_ip[s] : pool_ip[k],
                       tbl_valid[s] ? tbl_port[s] : pool_port[k], now,
                       $urandom_range(0, 9) == 0);
        end else if (r < 90) begin
            it = query(t_qkind'($urandom_range(0, 2)), t_cookie_mode'($urandom_range(0, 2)),
                       pool_ip[k], pool_port[k], cur_now, 0);
        end else begin
            it = random_item();
            if (it.action == uqcf_pkg::ACT_WRITE) it.action = uqcf_pkg::ACT_UDP;
            if ($urandom_range(0, 1)) begin
                it.dst_ip = pool_ip[k];
                it.dest_port = pool_port[k];
            end
        end
        send_item(it);
    endtask

    task automatic test_directed();
        uqcf_pkg::t_item it;
        it = random_item();
        it.action = uqcf_pkg::ACT_OTHER;
        send_item(it);
        it = random_item();
        it.action = uqcf_pkg::ACT_UNUSED;
        send_item(it);
        send_item(query(Q_PLAYER, CK_NONE, 32'h0, 16'h0, cur_now, 0));
        send_item(slot_write(63, 2'b01, 32'hFFFF_FFFF, 16'hFFFF, cur_now));
        send_item(slot_write(0, 2'b11, 32'h0, 16'h0, cur_now));
        send_item(slot_write(9, 2'b01, pool_ip[0], pool_port[0], cur_now));
        // A duplicate key in a higher slot must lose to the lower one.
        send_item(slot_write(40, 2'b11, pool_ip[0], pool_port[0], cur_now));
        send_item(query(Q_PLAYER, CK_NONE, 32'hFFFF_FFFF, 16'hFFFF, cur_now, 0));
        send_item(query(Q_RULES, CK_NONE, 32'h0, 16'h0, cur_now + 2, 0));
        send_item(query(Q_INFO, CK_NONE, pool_ip[0], pool_port[0], cur_now, 0));
        send_item(query(Q_PLAYER, CK_GOOD, 32'hFFFF_FFFF, 16'hFFFF, cur_now + 1, 0));
        send_item(query(Q_RULES, CK_GOOD, 32'h0, 16'h0, cur_now + 10, 0));
        send_item(query(Q_INFO, CK_GOOD, pool_ip[0], pool_port[0], cur_now + 3, 0));
        send_item(query(Q_INFO, CK_BAD, pool_ip[0], pool_port[0], cur_now, 0));
        send_item(query(Q_RULES, CK_BAD, 32'h0, 16'h0, cur_now, 0));
        // Stale entry: one second past the limit.
        send_item(query(Q_PLAYER, CK_NONE, 32'h0, 16'h0, cur_now + 11, 0));
        send_item(query(Q_INFO, CK_NONE, 32'h0, 16'h0, cur_now, 1));
        send_item(query(Q_PLAYER, CK_NONE, 32'hFFFF_FFFF, 16'hFFFF, cur_now, 1));
        it = random_item();
        it.action = uqcf_pkg::ACT_UDP;
        it.dst_ip = 32'h0;
        it.dest_port = 16'h0;
        it.now_seconds = cur_now;
        send_item(it);
        send_item(slot_write(0, 2'b00, 32'h0, 16'h0, cur_now));
        send_item(query(Q_RULES, CK_NONE, 32'h0, 16'h0, cur_now, 0));
    endtask

    task automatic test_random(int n);
        repeat (n) random_traffic();
    endtask

    task automatic test_backpressure();
        drain_results();
        hold_left = 300;
        no_gaps = 1;
        repeat (100) random_traffic();
        no_gaps = 0;
        drain_results();
    endtask

    task automatic test_config_sweep();
        logic [7:0] lims [4] = '{8'd0, 8'd255, 8'd3, 8'd10};
        logic [7:0] wins [4] = '{8'd255, 8'd0, 8'd200, 8'd5};
        for (int p = 0; p < 4; p++) begin
            write_cfg(uqcf_pkg::CFG_EXPIRY, lims[p]);
            write_cfg(uqcf_pkg::CFG_WINDOW, wins[p]);
            test_random(25);
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < 6; i++) begin
            pool_ip[i] = $urandom;
            pool_port[i] = 16'($urandom);
        end
        pool_ip[1] = 32'hFFFF_FFFF;
        pool_port[2] = 16'h0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);
        test_backpressure();
        test_config_sweep();
        drain_results();
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
src/uqcf_pkg.sv
src/uqcf_cell.sv
src/uqcf_classify.sv
src/udp_query_challenge_filter_core.sv
bench/tb_top.sv
